// ===== rtl/core/lkvc_pkg.sv =====
package lkvc_pkg;

  // Number of cells in the recency chain.
  localparam int ENTRIES = 16;

  // Field widths fixed by the request and response formats.
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // One stored entry as it moves along the chain.
  typedef struct packed {
    logic                      valid;
    logic signed [KEY_W-1:0]   key;
    logic        [VALUE_W-1:0] value;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;
    logic compare;
    logic update;
    logic hit;
    logic fill;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/lkvc_req_if.sv =====
interface lkvc_req_if import lkvc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [KEY_W-1:0]   key;
  logic        [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

// ===== rtl/core/lkvc_rsp_if.sv =====
interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/core/lkvc_cell.sv =====
// One position of the recency chain. Position 0 is the most recent entry;
// on an update a cell either keeps its entry or takes its upper neighbor's.
module lkvc_cell import lkvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctrl_t              ctrl,
  input  logic signed [KEY_W-1:0] cmp_key,
  input  logic                    in_cap,
  input  entry_t                  entry_in,
  output entry_t                  entry_out,
  input  logic                    seen_in,
  output logic                    seen_out,
  input  logic [VALUE_W-1:0]      hit_value_in,
  output logic [VALUE_W-1:0]      hit_value_out
);

  logic                    valid;
  logic signed [KEY_W-1:0] key;
  logic [VALUE_W-1:0]      value;
  logic                    match;
  logic                    shift;

  // Shift when the hit lies at or below this position, or on an insert.
  assign shift = ctrl.update && ((ctrl.hit && !seen_in) || ctrl.fill);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else if (ctrl.compare) begin
      match <= valid && (key == cmp_key);
    end else if (shift) begin
      valid <= entry_in.valid && in_cap;
    end
  end

  // Payload follows the shift without reset.
  always_ff @(posedge clk) begin
    if (shift && !ctrl.clear) begin
      key   <= entry_in.key;
      value <= entry_in.value;
    end
  end

  assign entry_out     = '{valid: valid, key: key, value: value};
  assign seen_out      = seen_in || match;
  assign hit_value_out = match ? value : hit_value_in;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement,
// built as a chain of cells ordered by recency (cell 0 most recent). When a
// request is accepted every cell compares its key with the request key; in
// the update state, once the response register is free, the chain shifts to
// move the hit or new entry to the front, dropping the entry that falls past
// the capacity. The response waits in an output register, so a new request is
// taken while the previous response is still pending. A get that hits
// returns the stored value; a put returns zero. Writing the capacity
// register empties the cache; a capacity of zero stores nothing.
module lru_key_value_cache import lkvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lkvc_req_if.sink          req,
  lkvc_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_t                  state;
  state_t                  state_next;
  logic [CAP_W-1:0]        capacity;
  logic                    cfg_write;
  logic                    req_put;
  logic signed [KEY_W-1:0] req_key;
  logic [VALUE_W-1:0]      req_value;
  logic                    rsp_valid;
  logic                    rsp_hit;
  logic [VALUE_W-1:0]      rsp_value;
  logic                    rsp_free;
  logic                    accept;
  logic                    do_update;
  logic                    any_hit;
  cell_ctrl_t              ctrl;
  entry_t                  head;
  entry_t                  ent     [ENTRIES];
  logic                    seen    [ENTRIES];
  logic [VALUE_W-1:0]      hit_val [ENTRIES];
  logic                    lim     [ENTRIES];

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CAPACITY);
  assign prdata    = (paddr[ADDR_W-1] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = 1'b0;
    do_update = 1'b0;
    unique case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_UPDATE: do_update = rsp_free;
      default:   req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept   = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;

  // Request register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_put   <= req.req_type;
      req_key   <= req.key;
      req_value <= req.value;
    end
  end

  // Cell control and the entry that enters at the front of the chain.
  assign any_hit      = seen[ENTRIES-1];
  assign ctrl.clear   = cfg_write;
  assign ctrl.compare = accept;
  assign ctrl.update  = do_update;
  assign ctrl.hit     = any_hit;
  assign ctrl.fill    = !any_hit && (req_put == REQ_PUT) && (capacity != '0);

  assign head.valid = 1'b1;
  assign head.key   = req_key;
  assign head.value = (req_put == REQ_PUT) ? req_value : hit_val[0];

  // Recency chain.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t             e_in;
    logic               s_in;
    logic [VALUE_W-1:0] h_in;

    assign lim[i] = 32'(capacity) > 32'(i);

    if (i == 0) begin : g_first
      assign e_in = head;
      assign s_in = 1'b0;
    end else begin : g_next
      assign e_in = ent[i-1];
      assign s_in = seen[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign h_in = '0;
    end else begin : g_mid
      assign h_in = hit_val[i+1];
    end

    lkvc_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .cmp_key       (req.key),
      .in_cap        (lim[i]),
      .entry_in      (e_in),
      .entry_out     (ent[i]),
      .seen_in       (s_in),
      .seen_out      (seen[i]),
      .hit_value_in  (h_in),
      .hit_value_out (hit_val[i])
    );
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (do_update) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      rsp_hit   <= any_hit;
      rsp_value <= (any_hit && (req_put == REQ_GET)) ? hit_val[0] : '0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

endmodule

// ===== dv/lru_key_value_cache_test.sv =====
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int REG_SPARE   = 1;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 120;

  // Result of one lookup as the block should return it.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } lookup_result_t;

  // One row of the directed plan: an optional register write before the request.
  typedef struct {
    bit                 cfg;
    int                 cfg_index;
    logic [DATA_W-1:0]  cfg_value;
    logic               req_type;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic               exp_hit;
    logic [VALUE_W-1:0] exp_value;
  } directed_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the cache contents and recency order.
  logic               cell_valid [ENTRIES];
  logic [KEY_W-1:0]   cell_key   [ENTRIES];
  logic [VALUE_W-1:0] cell_value [ENTRIES];
  int unsigned        cell_rank  [ENTRIES];
  int unsigned        occupancy;
  logic [CAP_W-1:0]   capacity_q;

  lookup_result_t expected_lookups [$];

  // Expectation typed into the directed plan travels with the request.
  logic               drv_typed;
  logic               drv_exp_hit;
  logic [VALUE_W-1:0] drv_exp_value;

  bit          gaps_on;
  bit          hold_request;
  int          error_count;
  int          idle_cycles;
  int          get_count;
  int          put_count;
  int          hit_count;
  int          cfg_writes;
  int          hold_count;
  logic [KEY_W-1:0] key_pool [$];
  directed_row_t    plan [$];

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Empty the shadow store, as a capacity write does.
  function automatic void clear_store();
    for (int i = 0; i < ENTRIES; i++) begin
      cell_valid[i] = 1'b0;
      cell_rank[i]  = 0;
    end
    occupancy = 0;
  endfunction

  // Apply one get or put to the shadow store and return the response it gives.
  function automatic lookup_result_t lru_access(input logic put, input logic [KEY_W-1:0] k,
                                                input logic [VALUE_W-1:0] v);
    lookup_result_t res;
    int idx;
    int slot;
    int limit;
    int unsigned r;
    res  = '0;
    idx  = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (idx < 0 && cell_valid[i] && cell_key[i] == k) idx = i;
    end
    if (idx >= 0) begin
      res.hit = 1'b1;
      if (put == REQ_PUT) cell_value[idx] = v;
      else res.read_value = cell_value[idx];
      // Entries more recent than the hit one age by one step.
      r = cell_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
        if (cell_valid[i] && cell_rank[i] < r) cell_rank[i]++;
      end
      cell_rank[idx] = 0;
    end else if (put == REQ_PUT) begin
      limit = (int'(capacity_q) < ENTRIES) ? int'(capacity_q) : ENTRIES;
      if (limit > 0) begin
        // A full store drops its least recent entry first.
        if (occupancy >= limit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (cell_valid[i] && cell_rank[i] == occupancy - 1) cell_valid[i] = 1'b0;
          end
          occupancy--;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (!cell_valid[i]) begin
            if (slot < 0) slot = i;
          end else begin
            cell_rank[i]++;
          end
        end
        if (slot >= 0) begin
          cell_valid[slot] = 1'b1;
          cell_key[slot]   = k;
          cell_value[slot] = v;
          cell_rank[slot]  = 0;
          occupancy++;
        end
      end
    end
    return res;
  endfunction

  // Requests are predicted on acceptance; responses are checked in order.
  always @(posedge clk) begin
    lookup_result_t pred;
    lookup_result_t want;
    if (!rst && req_ch.valid && req_ch.ready) begin
      pred = lru_access(req_ch.req_type, req_ch.key, req_ch.value);
      if (drv_typed) begin
        pred.hit        = drv_exp_hit;
        pred.read_value = drv_exp_value;
      end
      expected_lookups.push_back(pred);
      if (req_ch.req_type == REQ_PUT) put_count++;
      else get_count++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_lookups.size() == 0) begin
        error_count++;
        $display("%0t: response with no request waiting: hit %0b, read_value %h",
                 $realtime, rsp_ch.hit, rsp_ch.read_value);
      end else begin
        want = expected_lookups.pop_front();
        if (rsp_ch.hit) hit_count++;
        if (rsp_ch.hit !== want.hit) begin
          error_count++;
          $display("%0t: hit mismatch: expected %0b, actual %0b",
                   $realtime, want.hit, rsp_ch.hit);
        end
        if (rsp_ch.read_value !== want.read_value) begin
          error_count++;
          $display("%0t: read_value mismatch: expected %h, actual %h",
                   $realtime, want.read_value, rsp_ch.read_value);
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 10);
    end
  end

  // Offer one request and wait for the block to take it.
  task automatic send_request(input logic typ, input logic [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v, input bit typed,
                              input logic exp_hit, input logic [VALUE_W-1:0] exp_value);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= typ;
    req_ch.key      <= k;
    req_ch.value    <= v;
    drv_typed       <= typed;
    drv_exp_hit     <= exp_hit;
    drv_exp_value   <= exp_value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every response is back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register, then read the capacity back and compare it.
  task automatic program_register(input int idx, input logic [DATA_W-1:0] data);
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= data;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_CAPACITY) begin
      capacity_q = data[CAP_W-1:0];
      clear_store();
    end
    cfg_writes++;
    @(negedge clk);
    paddr   <= ADDR_W'(4 * REG_CAPACITY);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(capacity_q)) begin
      error_count++;
      $display("%0t: capacity readback mismatch: expected %h, actual %h",
               $realtime, DATA_W'(capacity_q), prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Draw a fresh set of keys a little larger than the capacity, so that
  // lookups hit often and puts keep evicting.
  task automatic refill_key_pool(input int cap);
    int n;
    n = ((cap < ENTRIES) ? cap : ENTRIES) + 3;
    key_pool.delete();
    repeat (n) key_pool.push_back($urandom);
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    int caps [10];

    caps            = '{16, 31, 1, 0, 5, 2, 16, 8, 3, 15};
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_GET;
    req_ch.key      = '0;
    req_ch.value    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    drv_typed       = 1'b0;
    drv_exp_hit     = 1'b0;
    drv_exp_value   = '0;
    gaps_on         = 1'b1;
    hold_request    = 1'b0;
    error_count     = 0;
    idle_cycles     = 0;
    get_count       = 0;
    put_count       = 0;
    hit_count       = 0;
    cfg_writes      = 0;
    hold_count      = 0;
    capacity_q      = CAPACITY_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      cell_key[i]   = '0;
      cell_value[i] = '0;
    end
    clear_store();

    // Directed plan. Columns: cfg, cfg_index, cfg_value, req_type, key, value,
    // typed, exp_hit, exp_value.
    // Empty cache after reset, key and value extremes, overwrite by put.
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_0000, 64'h0, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h8000_0000, '1, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h8000_0000, 64'h0, 1, 1, '1});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h7FFF_FFFF, 64'h0, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h7FFF_FFFF, '1, 1, 1, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 1, 1, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h8000_0000, 64'h0, 1, 1, 64'h0123_4567_89AB_CDEF});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h7FFF_FFFE, 64'h0, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'hFFFF_FFFF, 64'h0, 1, 1, 64'hA5A5_A5A5_5A5A_5A5A});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h0000_0000, 64'h5A5A_A5A5_0F0F_F0F0, 0, 0, 64'h0});
    // A capacity write empties the store; with capacity zero nothing is kept.
    plan.push_back('{1, REG_CAPACITY, 0, REQ_GET, 32'h8000_0000, 64'h0, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h0000_1234, 64'h1111, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_1234, 64'h0, 1, 0, 64'h0});
    // Capacity one: each new key pushes out the last.
    plan.push_back('{1, REG_CAPACITY, 1, REQ_PUT, 32'h0000_0001, 64'h0101, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h0000_0002, 64'h0202, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_0001, 64'h0, 1, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_0002, 64'h0, 1, 1, 64'h0202});
    // Capacity two: a get refreshes an entry so the other one is evicted.
    plan.push_back('{1, REG_CAPACITY, 2, REQ_PUT, 32'h0000_0010, 64'h1010, 0, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h0000_0011, 64'h1111, 0, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_0010, 64'h0, 0, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_PUT, 32'h0000_0012, 64'h1212, 0, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_0011, 64'h0, 0, 0, 64'h0});
    plan.push_back('{0, 0, 0, REQ_GET, 32'h0000_0010, 64'h0, 0, 0, 64'h0});
    // A write to an unmapped register leaves the contents alone.
    plan.push_back('{1, REG_SPARE, 0, REQ_GET, 32'h0000_0012, 64'h0, 0, 0, 64'h0});

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        drain();
        program_register(plan[i].cfg_index, plan[i].cfg_value);
      end
      send_request(plan[i].req_type, plan[i].key, plan[i].value, plan[i].typed,
                   plan[i].exp_hit, plan[i].exp_value);
    end

    // Random phases, one per capacity setting. One phase runs without any
    // stalls, and one starts with a long hold-off on the response side.
    foreach (caps[ph]) begin
      drain();
      program_register(REG_CAPACITY, DATA_W'(caps[ph]));
      refill_key_pool(caps[ph]);
      gaps_on = (ph != 6);
      if (ph == 2) hold_request = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else k = $urandom;
        send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, k, {$urandom, $urandom},
                     1'b0, 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Covered %0d gets and %0d puts with %0d hits over %0d register writes,",
             get_count, put_count, hit_count, cfg_writes);
    $display("capacities from zero to 31, and %0d long response hold-off(s).", hold_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_req_if.sv
rtl/core/lkvc_rsp_if.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache.sv
dv/lru_key_value_cache_test.sv
